>>> src/swfa_pkg.sv
// ----------------------------------------------------------------------------
// swfa_pkg
// Shared types and codes of the windowed fold analysis block.
// ----------------------------------------------------------------------------
package swfa_pkg;

    localparam logic [1:0] CFG_FFT_LEN    = 2'd0;
    localparam logic [1:0] CFG_WINDOW_LEN = 2'd1;
    localparam logic [1:0] CFG_HOP        = 2'd2;

    localparam logic OP_COEFF  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam int CMDQ_DEPTH = 4;
    localparam int OUT_DEPTH  = 4;

    typedef struct packed {
        logic [2:0] fft_len_log2;
        logic [3:0] window_len_log2;
    } t_frame_cfg;

    typedef struct packed {
        logic        op;
        logic [7:0]  coeff_index;
        logic [15:0] value;
        logic        frame;
        logic [5:0]  rotation;
    } t_cmd;

endpackage

>>> src/swfa_front.sv
// ----------------------------------------------------------------------------
// swfa_front
// Configuration registers, hop counting and frame triggering; turns each
// accepted word into a command for the back end.
// ----------------------------------------------------------------------------
module swfa_front #(
    parameter int MAX_FFT    = 64,
    parameter int MAX_WINDOW = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [3:0]            i_cfg_data,
    input  logic                  i_push,
    input  logic                  i_full,
    input  logic                  i_op,
    input  logic [7:0]            i_coeff_index,
    input  logic signed [15:0]    i_coeff_value,
    input  logic signed [15:0]    i_sample,
    output logic                  o_cmd_push,
    output swfa_pkg::t_cmd        o_cmd,
    output swfa_pkg::t_frame_cfg  o_frame_cfg
);
    import swfa_pkg::*;

    localparam int FLOG_MAX = $clog2(MAX_FFT + 1) - 1;
    localparam int WLOG_MAX = $clog2(MAX_WINDOW + 1) - 1;
    localparam logic [2:0] FLOG_CAP = (FLOG_MAX < 6) ? 3'(FLOG_MAX) : 3'd6;
    localparam logic [3:0] WLOG_CAP = (WLOG_MAX < 8) ? 4'(WLOG_MAX) : 4'd8;

    logic [2:0] r_fft_len_log2;
    logic [3:0] r_window_len_log2;
    logic [2:0] r_hop_log2;
    logic [6:0] r_hop_count;
    logic [5:0] r_rotation;

    logic [2:0] hop_eff;
    logic [6:0] hop_len;
    logic [6:0] hop_inc;
    logic       accept;
    logic       frame;

    always_comb begin
        if (r_fft_len_log2 < 3'd1) begin
            o_frame_cfg.fft_len_log2 = 3'd1;
        end else if (r_fft_len_log2 > FLOG_CAP) begin
            o_frame_cfg.fft_len_log2 = FLOG_CAP;
        end else begin
            o_frame_cfg.fft_len_log2 = r_fft_len_log2;
        end
        if (r_window_len_log2 < 4'd1) begin
            o_frame_cfg.window_len_log2 = 4'd1;
        end else if (r_window_len_log2 > WLOG_CAP) begin
            o_frame_cfg.window_len_log2 = WLOG_CAP;
        end else begin
            o_frame_cfg.window_len_log2 = r_window_len_log2;
        end
    end

    assign hop_eff = (r_hop_log2 > 3'd6) ? 3'd6 : r_hop_log2;
    assign hop_len = 7'd1 << hop_eff;
    assign hop_inc = r_hop_count + 7'd1;
    assign accept  = i_push & ~i_full;
    assign frame   = (i_op == OP_SAMPLE) && (hop_inc >= hop_len);

    assign o_cmd_push        = accept;
    assign o_cmd.op          = i_op;
    assign o_cmd.coeff_index = i_coeff_index;
    assign o_cmd.value       = (i_op == OP_SAMPLE) ? i_sample : i_coeff_value;
    assign o_cmd.frame       = frame;
    assign o_cmd.rotation    = r_rotation;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fft_len_log2    <= 3'd6;
            r_window_len_log2 <= 4'd6;
            r_hop_log2        <= 3'd4;
            r_hop_count       <= 7'd0;
            r_rotation        <= 6'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FFT_LEN:    r_fft_len_log2    <= i_cfg_data[2:0];
                    CFG_WINDOW_LEN: r_window_len_log2 <= i_cfg_data;
                    CFG_HOP:        r_hop_log2        <= i_cfg_data[2:0];
                    default: ;
                endcase
            end
            if (accept && (i_op == OP_SAMPLE)) begin
                if (frame) begin
                    r_hop_count <= 7'd0;
                    r_rotation  <= r_rotation + hop_len[5:0];
                end else begin
                    r_hop_count <= hop_inc;
                end
            end
        end
    end

endmodule

>>> src/swfa_cmdq.sv
// ----------------------------------------------------------------------------
// swfa_cmdq
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module swfa_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  swfa_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output swfa_pkg::t_cmd  o_cmd
);
    import swfa_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == (PW + 1)'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (PW + 1)'(do_push) - (PW + 1)'(do_pop);
        end
    end

endmodule

>>> src/swfa_back.sv
// ----------------------------------------------------------------------------
// swfa_back
// Executes commands: coefficient and sample stores, then for each frame a
// single-MAC pass over the window, bin by bin, into a small result queue.
// ----------------------------------------------------------------------------
module swfa_back #(
    parameter int MAX_FFT    = 64,
    parameter int MAX_WINDOW = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cmd_empty,
    input  swfa_pkg::t_cmd        i_cmd,
    input  swfa_pkg::t_frame_cfg  i_frame_cfg,
    output logic                  o_cmd_pop,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic [5:0]            o_bin_index,
    output logic signed [23:0]    o_folded_value,
    output logic                  o_last
);
    import swfa_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int IW    = $clog2(MAX_WINDOW + MAX_FFT + 1);
    localparam int SUM_W = 32 + $clog2(MAX_WINDOW);
    localparam int ACC_W = (SUM_W > 40) ? SUM_W : 40;
    localparam int QW    = ACC_W - 15;
    localparam int OPW   = $clog2(OUT_DEPTH);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic signed [15:0] r_ring [MAX_WINDOW];
    logic signed [15:0] r_coef [MAX_WINDOW];

    logic              r_state;
    logic [AW-1:0]     r_wp;
    logic [CW-1:0]     r_fill;
    logic [5:0]        r_rot;
    logic [AW-1:0]     r_base;
    logic [6:0]        r_k;
    logic [IW-1:0]     r_i;
    logic              r_first;

    logic signed [15:0] r_ring_q;
    logic signed [15:0] r_coef_q;
    logic              r_s1_valid;
    logic              r_s1_use;
    logic              r_s1_first;
    logic              r_s1_last;
    logic [5:0]        r_s1_k;
    logic              r_s1_flast;

    logic              r_s2_valid;
    logic signed [31:0] r_s2_prod;
    logic              r_s2_first;
    logic              r_s2_last;
    logic [5:0]        r_s2_k;
    logic              r_s2_flast;

    logic signed [ACC_W-1:0] r_acc;

    logic [5:0]        r_ob_bin  [OUT_DEPTH];
    logic [23:0]       r_ob_val  [OUT_DEPTH];
    logic              r_ob_last [OUT_DEPTH];
    logic [OPW-1:0]    r_owr;
    logic [OPW-1:0]    r_ord;
    logic [OPW:0]      r_ocnt;
    logic [OPW:0]      r_credit;

    logic [6:0]        f_len;
    logic [5:0]        f_mask;
    logic [CW-1:0]     w_len;
    logic [AW:0]       wp_inc;
    logic [AW-1:0]     wp_next;
    logic [AW:0]       base_sum;
    logic [AW-1:0]     base_new;
    logic [31:0]       ci_ext;
    logic              ci_ok;
    logic              cmd_take;

    logic              tok_zero;
    logic [IW-1:0]     i_next;
    logic              tok_last;
    logic              issue;
    logic [AW:0]       ring_sum;
    logic [AW-1:0]     ring_addr;
    logic              sample_ok;
    logic [6:0]        k_next;

    logic signed [ACC_W-1:0] acc_sum;
    logic signed [QW-1:0]    q;
    logic [QW-24:0]          q_top;
    logic [23:0]             sat_val;
    logic                    ob_push;
    logic                    ob_pop;

    assign f_len  = 7'd1 << i_frame_cfg.fft_len_log2;
    assign f_mask = 6'(f_len - 7'd1);
    assign w_len  = CW'(1) << i_frame_cfg.window_len_log2;

    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;
    assign cmd_take  = o_cmd_pop;

    assign wp_inc   = (AW + 1)'(r_wp) + (AW + 1)'(1);
    assign wp_next  = (wp_inc == (AW + 1)'(MAX_WINDOW)) ? '0 : wp_inc[AW-1:0];
    assign base_sum = (AW + 1)'(wp_next) + (AW + 1)'(MAX_WINDOW) - (AW + 1)'(w_len);
    assign base_new = (base_sum >= (AW + 1)'(MAX_WINDOW))
                    ? AW'(base_sum - (AW + 1)'(MAX_WINDOW)) : base_sum[AW-1:0];

    assign ci_ext = 32'(i_cmd.coeff_index);
    assign ci_ok  = ci_ext < 32'(MAX_WINDOW);

    assign tok_zero  = r_i >= IW'(w_len);
    assign i_next    = r_i + IW'(f_len);
    assign tok_last  = tok_zero || (i_next >= IW'(w_len));
    assign issue     = (r_state == S_RUN)
                    && (!tok_last || (r_credit < (OPW + 1)'(OUT_DEPTH)));
    assign ring_sum  = (AW + 1)'(r_base) + (AW + 1)'(r_i[AW-1:0]);
    assign ring_addr = (ring_sum >= (AW + 1)'(MAX_WINDOW))
                     ? AW'(ring_sum - (AW + 1)'(MAX_WINDOW)) : ring_sum[AW-1:0];
    assign sample_ok = (r_fill == CW'(MAX_WINDOW)) || (CW'(ring_addr) < r_fill);
    assign k_next    = r_k + 7'd1;

    assign acc_sum = r_s2_first ? ACC_W'(r_s2_prod) : r_acc + ACC_W'(r_s2_prod);
    assign q       = QW'(acc_sum >>> 15);
    assign q_top   = q[QW-1:23];

    always_comb begin
        if ((&q_top) || !(|q_top)) begin
            sat_val = q[23:0];
        end else if (q[QW-1]) begin
            sat_val = 24'h800000;
        end else begin
            sat_val = 24'h7FFFFF;
        end
    end

    assign ob_push        = r_s2_valid && r_s2_last;
    assign o_empty        = (r_ocnt == '0);
    assign ob_pop         = i_pop && !o_empty;
    assign o_bin_index    = r_ob_bin[r_ord];
    assign o_folded_value = r_ob_val[r_ord];
    assign o_last         = r_ob_last[r_ord];

    always_ff @(posedge i_clk) begin
        if (cmd_take && (i_cmd.op == OP_SAMPLE)) begin
            r_ring[r_wp] <= i_cmd.value;
        end
        r_ring_q <= r_ring[ring_addr];
    end

    always_ff @(posedge i_clk) begin
        if (cmd_take && (i_cmd.op == OP_COEFF) && ci_ok) begin
            r_coef[ci_ext[AW-1:0]] <= i_cmd.value;
        end
        r_coef_q <= r_coef[r_i[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (ob_push) begin
            r_ob_bin[r_owr]  <= r_s2_k;
            r_ob_val[r_owr]  <= sat_val;
            r_ob_last[r_owr] <= r_s2_flast;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_use   <= !tok_zero && sample_ok;
        r_s1_first <= r_first;
        r_s1_last  <= tok_last;
        r_s1_k     <= r_k[5:0];
        r_s1_flast <= (k_next == f_len);
        r_s2_prod  <= r_s1_use ? r_ring_q * r_coef_q : 32'sd0;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        r_s2_k     <= r_s1_k;
        r_s2_flast <= r_s1_flast;
        if (r_s2_valid) begin
            r_acc <= acc_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wp       <= '0;
            r_fill     <= '0;
            r_rot      <= '0;
            r_base     <= '0;
            r_k        <= '0;
            r_i        <= '0;
            r_first    <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_owr      <= '0;
            r_ord      <= '0;
            r_ocnt     <= '0;
            r_credit   <= '0;
        end else begin
            r_s1_valid <= issue;
            r_s2_valid <= r_s1_valid;
            case (r_state)
                S_IDLE: begin
                    if (cmd_take && (i_cmd.op == OP_SAMPLE)) begin
                        r_wp <= wp_next;
                        if (r_fill != CW'(MAX_WINDOW)) begin
                            r_fill <= r_fill + CW'(1);
                        end
                        if (i_cmd.frame) begin
                            r_state <= S_RUN;
                            r_rot   <= i_cmd.rotation;
                            r_base  <= base_new;
                            r_k     <= '0;
                            r_i     <= IW'((6'd0 - i_cmd.rotation) & f_mask);
                            r_first <= 1'b1;
                        end
                    end
                end
                S_RUN: begin
                    if (issue) begin
                        if (tok_last) begin
                            r_first <= 1'b1;
                            if (k_next == f_len) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_k <= k_next;
                                r_i <= IW'((k_next[5:0] - r_rot) & f_mask);
                            end
                        end else begin
                            r_first <= 1'b0;
                            r_i     <= i_next;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (ob_push) begin
                r_owr <= r_owr + 1'b1;
            end
            if (ob_pop) begin
                r_ord <= r_ord + 1'b1;
            end
            r_ocnt   <= r_ocnt + (OPW + 1)'(ob_push) - (OPW + 1)'(ob_pop);
            r_credit <= r_credit + (OPW + 1)'(issue && tok_last) - (OPW + 1)'(ob_pop);
        end
    end

endmodule

>>> src/stft_windowed_fold_analysis_top.sv
// ----------------------------------------------------------------------------
// stft_windowed_fold_analysis_top
// Windowed fold analysis: sample ring, window store and folding MAC.
// ----------------------------------------------------------------------------
// Coefficient and non-frame sample words are simple stores in the back end.
// A frame-closing sample holds the back end for the whole fold, one MAC per
// tap or empty bin; folded words then leave bin by bin, and the fold stalls
// at the end of a bin while the result queue has no room.
// The single MAC and the one read port of each store set the frame time.
// Reset clears control state; the sample ring reads as zero until written.
module stft_windowed_fold_analysis_top #(
    parameter int MAX_FFT    = 64,
    parameter int MAX_WINDOW = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [3:0]         i_cfg_data,
    input  logic               push,
    output logic               full,
    input  logic               i_op,
    input  logic [7:0]         i_coeff_index,
    input  logic signed [15:0] i_coeff_value,
    input  logic signed [15:0] i_sample,
    output logic               empty,
    input  logic               pop,
    output logic [5:0]         o_bin_index,
    output logic signed [23:0] o_folded_value,
    output logic               o_last
);
    import swfa_pkg::*;

    logic       cmd_push;
    t_cmd       cmd_in;
    t_cmd       cmd_out;
    logic       cmd_pop;
    logic       cmd_empty;
    t_frame_cfg frame_cfg;

    swfa_front #(
        .MAX_FFT    (MAX_FFT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_push        (push),
        .i_full        (full),
        .i_op          (i_op),
        .i_coeff_index (i_coeff_index),
        .i_coeff_value (i_coeff_value),
        .i_sample      (i_sample),
        .o_cmd_push    (cmd_push),
        .o_cmd         (cmd_in),
        .o_frame_cfg   (frame_cfg)
    );

    swfa_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (cmd_in),
        .i_pop   (cmd_pop),
        .o_full  (full),
        .o_empty (cmd_empty),
        .o_cmd   (cmd_out)
    );

    swfa_back #(
        .MAX_FFT    (MAX_FFT),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_empty    (cmd_empty),
        .i_cmd          (cmd_out),
        .i_frame_cfg    (frame_cfg),
        .o_cmd_pop      (cmd_pop),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_bin_index    (o_bin_index),
        .o_folded_value (o_folded_value),
        .o_last         (o_last)
    );

endmodule

>>> tb/tb_stft_windowed_fold_analysis_top.sv
// ----------------------------------------------------------------------------
// tb_stft_windowed_fold_analysis_top
// Self-checking bench for the windowed fold analysis block. Coefficient and
// sample words are fed through the push side with random gaps. A cycle-free
// model of the ring, the window store and the fold predicts every folded
// word. The pop side checks each word in order against that prediction.
// ----------------------------------------------------------------------------
module tb_stft_windowed_fold_analysis_top;

    import swfa_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int         RING_LEN  = 256;

    typedef struct {
        logic               op;
        logic [7:0]         cidx;
        logic signed [15:0] cval;
        logic signed [15:0] smp;
    } t_audio_word;

    typedef struct packed {
        logic [5:0]         bin;
        logic signed [23:0] value;
        logic               last;
    } t_bin_word;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_we       = 1'b0;
    logic [1:0]         i_cfg_index    = '0;
    logic [3:0]         i_cfg_data     = '0;
    logic               push           = 1'b0;
    logic               full;
    logic               i_op           = 1'b0;
    logic [7:0]         i_coeff_index  = '0;
    logic signed [15:0] i_coeff_value  = '0;
    logic signed [15:0] i_sample       = '0;
    logic               empty;
    logic               pop            = 1'b0;
    logic [5:0]         o_bin_index;
    logic signed [23:0] o_folded_value;
    logic               o_last;

    stft_windowed_fold_analysis_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_op           (i_op),
        .i_coeff_index  (i_coeff_index),
        .i_coeff_value  (i_coeff_value),
        .i_sample       (i_sample),
        .empty          (empty),
        .pop            (pop),
        .o_bin_index    (o_bin_index),
        .o_folded_value (o_folded_value),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // analysis model state
    logic signed [15:0] ring_mdl [RING_LEN];
    logic signed [15:0] coef_mdl [RING_LEN];
    logic [7:0]         wr_ptr_mdl  = '0;
    logic [6:0]         hop_cnt_mdl = '0;
    logic [5:0]         rot_mdl     = '0;
    logic [2:0]         fft_reg_mdl = 3'd6;
    logic [3:0]         win_reg_mdl = 4'd6;
    logic [2:0]         hop_reg_mdl = 3'd4;

    t_bin_word   due_bins [$];
    t_audio_word pending_words [$];
    bit          coef_planned [RING_LEN];

    t_audio_word cur_word = '{1'b0, 8'd0, 16'sd0, 16'sd0};
    t_bin_word   got_bin;
    bit          offering   = 1'b0;
    bit          steady     = 1'b0;
    int          tx_gap     = 0;
    int          rx_gap     = 0;
    int          rx_hold    = 0;
    int          hold_asked = 0;
    int          hold_done  = 0;
    int          n_queued   = 0;
    int          n_taken    = 0;
    int          errs       = 0;

    initial begin
        for (int i = 0; i < RING_LEN; i++) begin
            ring_mdl[i]     = '0;
            coef_mdl[i]     = '0;
            coef_planned[i] = 1'b0;
        end
    end

    function automatic int unsigned clamp_u(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int unsigned frame_words();
        return 1 << clamp_u(fft_reg_mdl, 1, 6);
    endfunction

    function automatic int unsigned window_taps();
        return 1 << clamp_u(win_reg_mdl, 1, 8);
    endfunction

    function automatic int unsigned hop_size();
        return 1 << clamp_u(hop_reg_mdl, 0, 6);
    endfunction

    function automatic void analyse_word(t_audio_word w);
        longint      acc [64];
        longint      q;
        int unsigned f, wl, h, n, pos;
        t_bin_word   b;
        if (w.op == OP_COEFF) begin
            coef_mdl[w.cidx] = w.cval;
            return;
        end
        ring_mdl[wr_ptr_mdl] = w.smp;
        wr_ptr_mdl  = wr_ptr_mdl + 8'd1;
        hop_cnt_mdl = hop_cnt_mdl + 7'd1;
        h = hop_size();
        if (hop_cnt_mdl < h)
            return;
        hop_cnt_mdl = '0;
        f  = frame_words();
        wl = window_taps();
        for (int i = 0; i < 64; i++)
            acc[i] = 0;
        n = rot_mdl % f;
        for (int unsigned i = 0; i < wl; i++) begin
            pos = (wr_ptr_mdl + RING_LEN - wl + i) % RING_LEN;
            acc[n] += longint'(ring_mdl[pos]) * longint'(coef_mdl[i]);
            n++;
            if (n == f)
                n = 0;
        end
        for (int unsigned i = 0; i < f; i++) begin
            q = acc[i] >>> 15;
            if (q > 64'sd8388607)
                q = 64'sd8388607;
            if (q < -64'sd8388608)
                q = -64'sd8388608;
            b.bin   = i[5:0];
            b.value = q[23:0];
            b.last  = (i == f - 1);
            due_bins.push_back(b);
        end
        rot_mdl = rot_mdl + h[5:0];
    endfunction

    function automatic logic signed [15:0] rand_audio();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(0, 15)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_word(logic op, logic [7:0] idx, logic signed [15:0] cval,
                              logic signed [15:0] smp);
        t_audio_word w;
        w.op   = op;
        w.cidx = idx;
        w.cval = cval;
        w.smp  = smp;
        pending_words.push_back(w);
        n_queued++;
    endtask

    task automatic queue_coeff(logic [7:0] idx, logic signed [15:0] v);
        coef_planned[idx] = 1'b1;
        queue_word(OP_COEFF, idx, v, 16'($urandom));
    endtask

    task automatic queue_sample(logic signed [15:0] v);
        queue_word(OP_SAMPLE, 8'($urandom), 16'($urandom), v);
    endtask

    task automatic load_missing_coeffs();
        for (int unsigned i = 0; i < window_taps(); i++)
            if (!coef_planned[i])
                queue_coeff(i[7:0], rand_audio());
    endtask

    task automatic set_reg(logic [1:0] idx, logic [3:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_FFT_LEN:    fft_reg_mdl = data[2:0];
            CFG_WINDOW_LEN: win_reg_mdl = data;
            CFG_HOP:        hop_reg_mdl = data[2:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        do
            @(posedge i_clk);
        while (n_taken != n_queued || due_bins.size() != 0);
        repeat (32) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            offering = 1'b0;
            tx_gap   = 0;
        end else begin
            if (push && !full) begin
                analyse_word(cur_word);
                n_taken++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (!steady && $urandom_range(0, 9) == 0)
                    tx_gap = $urandom_range(1, 8) - 1;
                else if (pending_words.size() > 0) begin
                    cur_word = pending_words.pop_front();
                    offering = 1'b1;
                end
            end
            push          <= offering;
            i_op          <= cur_word.op;
            i_coeff_index <= cur_word.cidx;
            i_coeff_value <= cur_word.cval;
            i_sample      <= cur_word.smp;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop    <= 1'b0;
            rx_gap = 0;
        end else begin
            if (pop && !empty) begin
                if (due_bins.size() == 0) begin
                    $error("unexpected word: bin_index %0d folded_value %0d last %0b",
                           o_bin_index, o_folded_value, o_last);
                    errs++;
                end else begin
                    got_bin = due_bins.pop_front();
                    if (o_bin_index !== got_bin.bin) begin
                        $error("bin_index: expected %0d, got %0d", got_bin.bin, o_bin_index);
                        errs++;
                    end
                    if (o_folded_value !== got_bin.value) begin
                        $error("folded_value: expected %0d, got %0d",
                               got_bin.value, o_folded_value);
                        errs++;
                    end
                    if (o_last !== got_bin.last) begin
                        $error("last: expected %0b, got %0b", got_bin.last, o_last);
                        errs++;
                    end
                end
            end
            if (hold_asked != hold_done) begin
                rx_hold   = 400;
                hold_done = hold_asked;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                pop <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                pop <= 1'b0;
            end else if (!steady && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(1, 8) - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int unsigned n_items;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two-tap window, two bins, a frame on every sample
        set_reg(CFG_FFT_LEN, 4'd1);
        set_reg(CFG_WINDOW_LEN, 4'd1);
        set_reg(CFG_HOP, 4'd0);
        queue_coeff(8'd0, 16'sh8000);
        queue_coeff(8'd1, 16'sh7fff);
        queue_sample(16'sh8000);
        queue_sample(16'sh8000);
        queue_sample(16'sh7fff);
        queue_sample(16'sh0001);
        settle();

        // window shorter than frame: empty bins read zero
        set_reg(CFG_FFT_LEN, 4'd3);
        set_reg(CFG_HOP, 4'd1);
        set_reg(CFG_SPARE, 4'd15);
        queue_sample(16'sh7fff);
        queue_sample(-16'sd1);
        settle();

        // clamp low settings; hop wider than frame and window
        set_reg(CFG_FFT_LEN, 4'd0);
        set_reg(CFG_WINDOW_LEN, 4'd0);
        set_reg(CFG_HOP, 4'd3);
        for (int i = 0; i < 11; i++)
            queue_sample(rand_audio());
        settle();

        // hop lowered with a count already past it
        set_reg(CFG_HOP, 4'd1);
        queue_sample(16'sh8000);
        settle();

        // long receiver hold with samples streaming in
        set_reg(CFG_FFT_LEN, 4'd2);
        set_reg(CFG_WINDOW_LEN, 4'd3);
        set_reg(CFG_HOP, 4'd0);
        load_missing_coeffs();
        hold_asked++;
        for (int i = 0; i < 30; i++)
            queue_sample(rand_audio());
        settle();

        // clamp high settings: full frame, full window, widest hop
        set_reg(CFG_FFT_LEN, 4'd7);
        set_reg(CFG_WINDOW_LEN, 4'd15);
        set_reg(CFG_HOP, 4'd7);
        load_missing_coeffs();
        for (int i = 0; i < 66; i++)
            queue_sample(rand_audio());
        settle();

        set_reg(CFG_FFT_LEN, 4'd6);
        set_reg(CFG_WINDOW_LEN, 4'd8);
        set_reg(CFG_HOP, 4'd0);
        for (int i = 0; i < 8; i++)
            queue_sample(rand_audio());
        settle();

        for (int ph = 0; ph < 8; ph++) begin
            set_reg(CFG_FFT_LEN, 4'($urandom_range(0, 15)));
            set_reg(CFG_WINDOW_LEN, 4'($urandom_range(0, 15)));
            set_reg(CFG_HOP, 4'($urandom_range(0, 15)));
            if ($urandom_range(0, 3) == 0)
                set_reg(CFG_SPARE, 4'($urandom_range(0, 15)));
            load_missing_coeffs();
            if (ph == 7)
                steady = 1'b1;
            n_items = $urandom_range(5, 15);
            for (int unsigned i = 0; i < n_items; i++) begin
                if ($urandom_range(0, 6) == 0)
                    queue_coeff(8'($urandom_range(0, 255)), rand_audio());
                else
                    queue_sample(rand_audio());
            end
            settle();
        end

        if (errs == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
